// ===== rtl/core/cds_pkg.sv =====
// Shared types, constants and calendar helpers for the calendar day stepper.
// Used by cds_next, calendar_day_stepper_top, cds_checker and the testbench; no dependencies.
`default_nettype none

package cds_pkg;

    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;

    typedef enum logic [1:0] {
        OP_UP   = 2'd0,
        OP_DOWN = 2'd1,
        OP_LOAD = 2'd2
    } op_t;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
        day_t   length;
    } date_t;

    localparam year_t  RESET_YEAR   = 14'd2000;
    localparam month_t RESET_MONTH  = 4'd1;
    localparam day_t   RESET_DAY    = 5'd1;
    localparam day_t   RESET_LENGTH = 5'd31;

    localparam month_t MONTH_FIRST = 4'd1;
    localparam month_t MONTH_LAST  = 4'd12;

    // Register indexes on the configuration port.
    localparam int unsigned REG_WRAP_IN_MONTH = 0;

    // Inverse of 25 modulo 2**14. A 14-bit value is a multiple of 25 exactly
    // when its product with the inverse, kept to 14 bits, is at most 655.
    localparam year_t INV25     = 14'd7209;
    localparam year_t DIV25_MAX = 14'd655;

    // Input beat fields, lowest bit first.
    localparam int unsigned IN_OP_LSB    = 0;
    localparam int unsigned IN_YEAR_LSB  = 2;
    localparam int unsigned IN_MONTH_LSB = 16;
    localparam int unsigned IN_DAY_LSB   = 20;

    // Result beat fields, lowest bit first.
    localparam int unsigned OUT_YEAR_LSB   = 0;
    localparam int unsigned OUT_MONTH_LSB  = 14;
    localparam int unsigned OUT_DAY_LSB    = 18;
    localparam int unsigned OUT_LENGTH_LSB = 23;
    localparam int unsigned OUT_WRAP_BIT   = 28;

    // Gregorian leap rule: divisible by 4 and not by 100, or divisible by 400.
    // With divisibility by 4 given, 100 reduces to 25 and 400 to 16.
    function automatic logic is_leap(input year_t y);
        logic [27:0] prod;
        logic        div25;
        prod  = 28'(y) * 28'(INV25);
        div25 = (prod[13:0] <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // Days in a month; a month code outside 1..12 reads as January.
    function automatic day_t month_len(input year_t y, input month_t m);
        day_t len;
        case (m) inside
            4'd2:                   len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/calendar_day_stepper_top.sv =====
// Calendar day stepper: date registers, result register and APB register.
// Depends on cds_pkg and cds_next.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while results are taken, set by the single date register update.
// s_axis_tready is high whenever the result register is empty or being taken.
// Reset sets the date to 2000-01-01 (31 days), clears wrap_in_month and
// empties the result register; no clearing pass is needed.
`default_nettype none

module calendar_day_stepper_top #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [15:2] load_year, [19:16] load_month, [24:20] load_day, rest zero
    input  logic [31:0] s_axis_tdata,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] year_now, [17:14] month_now, [22:18] day_now,
    // [27:23] month_length, [28] month_wrapped, rest zero
    output logic [31:0] m_axis_tdata
);
    import cds_pkg::*;

    logic        wrap_in_month_reg;
    date_t       date_reg;
    date_t       date_next;
    logic        wrapped_next;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        in_beat;
    logic        cfg_write;
    logic        cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == 1'(REG_WRAP_IN_MONTH));
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? {31'd0, wrap_in_month_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_in_month_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            wrap_in_month_reg <= pwdata[0];
        end
    end

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    cds_next #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_next (
        .cur           (date_reg),
        .wrap_in_month (wrap_in_month_reg),
        .op            (s_axis_tdata[IN_OP_LSB +: 2]),
        .load_year     (s_axis_tdata[IN_YEAR_LSB +: 14]),
        .load_month    (s_axis_tdata[IN_MONTH_LSB +: 4]),
        .load_day      (s_axis_tdata[IN_DAY_LSB +: 5]),
        .nxt           (date_next),
        .wrapped       (wrapped_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.year   <= RESET_YEAR;
            date_reg.month  <= RESET_MONTH;
            date_reg.day    <= RESET_DAY;
            date_reg.length <= RESET_LENGTH;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                date_reg      <= date_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            out_data_reg <= {3'd0, wrapped_next, date_next.length, date_next.day,
                             date_next.month, date_next.year};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cds_next.sv =====
// Next-date logic: steps the day up or down with carry, loads a date, or keeps it for any other op.
// Depends on cds_pkg for the date type, op codes and month length function.
`default_nettype none

module cds_next #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  cds_pkg::date_t  cur,
    input  logic            wrap_in_month,
    input  logic [1:0]      op,
    input  cds_pkg::year_t  load_year,
    input  cds_pkg::month_t load_month,
    input  cds_pkg::day_t   load_day,
    output cds_pkg::date_t  nxt,
    output logic            wrapped
);
    import cds_pkg::*;

    localparam year_t YEAR_MAX = 14'(YEAR_LIMIT);

    year_t  yr_sel;
    month_t mo_sel;
    day_t   len_sel;
    year_t  ld_year;
    month_t ld_month;
    logic   day_at_end;
    logic   day_at_start;

    assign ld_year  = (load_year > YEAR_MAX) ? YEAR_MAX : load_year;
    assign ld_month = (load_month < MONTH_FIRST) ? MONTH_FIRST :
                      (load_month > MONTH_LAST)  ? MONTH_LAST  : load_month;

    assign day_at_end   = (cur.day >= cur.length);
    assign day_at_start = (cur.day <= 5'd1);

    // Year and month after the item; the month length always follows them.
    always_comb
    begin
        yr_sel  = cur.year;
        mo_sel  = cur.month;
        wrapped = 1'b0;
        case (op)
            OP_UP:
            begin
                if (day_at_end)
                begin
                    wrapped = 1'b1;
                    if (!wrap_in_month)
                    begin
                        if (cur.month >= MONTH_LAST)
                        begin
                            mo_sel = MONTH_FIRST;
                            yr_sel = (cur.year >= YEAR_MAX) ? '0 : cur.year + 14'd1;
                        end
                        else
                        begin
                            mo_sel = cur.month + 4'd1;
                        end
                    end
                end
            end
            OP_DOWN:
            begin
                if (day_at_start)
                begin
                    wrapped = 1'b1;
                    if (!wrap_in_month)
                    begin
                        if (cur.month <= MONTH_FIRST)
                        begin
                            mo_sel = MONTH_LAST;
                            yr_sel = (cur.year == '0) ? YEAR_MAX : cur.year - 14'd1;
                        end
                        else
                        begin
                            mo_sel = cur.month - 4'd1;
                        end
                    end
                end
            end
            OP_LOAD:
            begin
                yr_sel  = ld_year;
                mo_sel  = ld_month;
                wrapped = (ld_year != cur.year) || (ld_month != cur.month);
            end
            default:
            begin
                yr_sel = cur.year;
            end
        endcase
    end

    assign len_sel = month_len(yr_sel, mo_sel);

    always_comb
    begin
        nxt.year   = yr_sel;
        nxt.month  = mo_sel;
        nxt.length = len_sel;
        nxt.day    = cur.day;
        case (op)
            OP_UP:
            begin
                nxt.day = day_at_end ? 5'd1 : cur.day + 5'd1;
            end
            OP_DOWN:
            begin
                nxt.day = day_at_start ? len_sel : cur.day - 5'd1;
            end
            OP_LOAD:
            begin
                nxt.day = (load_day < 5'd1)    ? 5'd1    :
                          (load_day > len_sel) ? len_sel : load_day;
            end
            default:
            begin
                nxt.day = cur.day;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cds_checker.sv =====
// Port-level checks for calendar_day_stepper_top, attached by a bind below.
// Depends on cds_pkg for the result beat field positions.
`default_nettype none

module cds_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata
);
    import cds_pkg::*;

    logic [3:0] mon;
    logic [4:0] dom;
    logic [4:0] len;

    assign mon = m_axis_tdata[OUT_MONTH_LSB +: 4];
    assign dom = m_axis_tdata[OUT_DAY_LSB +: 5];
    assign len = m_axis_tdata[OUT_LENGTH_LSB +: 5];

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Every accepted input beat is followed by a result beat.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // With the result register empty the block takes input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // The reported month, day and month length are always in range.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (mon != 4'd0) && (mon <= 4'd12) && (dom != 5'd0) &&
                          (dom <= len) && (len >= 5'd28) && (len <= 5'd31))
        else $error("result date out of range");

    // Stepping with the previous date in place never leaves the result stale:
    // a new beat taken while one waits means the waiting one went out.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && s_axis_tvalid && s_axis_tready |-> m_axis_tready)
        else $error("result beat overwritten before it was taken");

endmodule

bind calendar_day_stepper_top cds_checker u_cds_checker (.*);

`default_nettype wire

// ===== sim/calendar_day_stepper_top_tb.sv =====
// Self-checking testbench for calendar_day_stepper_top: steps, loads and
// register writes on the stream and APB ports, with a date predictor in a scoreboard.
// Depends on cds_pkg and the calendar_day_stepper_top RTL.
`default_nettype none

module calendar_day_stepper_top_tb;

    import cds_pkg::*;

    localparam int unsigned YEAR_LIMIT  = 9999;
    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned RANDOM_PHASES = 4;
    localparam int unsigned PHASE_BEATS   = 200;
    localparam int unsigned MAX_IDLE      = 13;

    // The op encoding left unused by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        year_t  year;
        month_t month;
        day_t   day;
        day_t   length;
        logic   wrapped;
    } date_result_t;

    class date_scoreboard;
        year_t        year;
        month_t       month;
        day_t         day;
        day_t         length;
        logic         wrap_in_month;
        date_result_t expected_q[$];
        int unsigned  failures;
        int unsigned  results_checked;
        int unsigned  wraps_flagged;
        int unsigned  year_carries;

        function new();
            year          = 14'd2000;
            month         = 4'd1;
            day           = 5'd1;
            length        = 5'd31;
            wrap_in_month = 1'b0;
        endfunction

        function day_t days_in_month(int unsigned y, int unsigned m);
            int unsigned lengths[12];
            bit          leap;
            lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            if (m < 1 || m > 12)
                m = 1;
            return day_t'(lengths[m - 1] + ((m == 2 && leap) ? 1 : 0));
        endfunction

        function void note_input(logic [31:0] beat);
            date_result_t result;
            int unsigned  y;
            int unsigned  m;
            int unsigned  d;
            logic         wrapped;
            wrapped = 1'b0;
            case (beat[IN_OP_LSB +: 2])
                OP_UP:
                begin
                    if (day >= length) begin
                        day     = 5'd1;
                        wrapped = 1'b1;
                        if (!wrap_in_month) begin
                            if (month >= 12) begin
                                month = 4'd1;
                                if (year >= YEAR_LIMIT)
                                    year_carries++;
                                year = (year >= YEAR_LIMIT) ? 14'd0 : year + 14'd1;
                            end
                            else
                                month = month + 4'd1;
                            length = days_in_month(year, month);
                        end
                    end
                    else
                        day = day + 5'd1;
                end
                OP_DOWN:
                begin
                    if (day <= 1) begin
                        wrapped = 1'b1;
                        if (!wrap_in_month) begin
                            if (month <= 1) begin
                                month = 4'd12;
                                if (year == 0)
                                    year_carries++;
                                year = (year == 0) ? year_t'(YEAR_LIMIT) : year - 14'd1;
                            end
                            else
                                month = month - 4'd1;
                            length = days_in_month(year, month);
                        end
                        day = length;
                    end
                    else
                        day = day - 5'd1;
                end
                OP_LOAD:
                begin
                    y = beat[IN_YEAR_LSB +: 14];
                    m = beat[IN_MONTH_LSB +: 4];
                    d = beat[IN_DAY_LSB +: 5];
                    if (y > YEAR_LIMIT)
                        y = YEAR_LIMIT;
                    if (m < 1)
                        m = 1;
                    if (m > 12)
                        m = 12;
                    wrapped = (y != year) || (m != month);
                    year    = year_t'(y);
                    month   = month_t'(m);
                    length  = days_in_month(y, m);
                    if (d < 1)
                        d = 1;
                    if (d > length)
                        d = length;
                    day = day_t'(d);
                end
                default:
                begin
                    // The unused op leaves the date alone and only reports it.
                end
            endcase
            result.year    = year;
            result.month   = month;
            result.day     = day;
            result.length  = length;
            result.wrapped = wrapped;
            expected_q.push_back(result);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [31:0] beat);
            date_result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                $error("result beat %h arrived with nothing expected", beat);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (want.wrapped)
                wraps_flagged++;
            compare_field("year_now", want.year, beat[OUT_YEAR_LSB +: 14]);
            compare_field("month_now", want.month, beat[OUT_MONTH_LSB +: 4]);
            compare_field("day_now", want.day, beat[OUT_DAY_LSB +: 5]);
            compare_field("month_length", want.length, beat[OUT_LENGTH_LSB +: 5]);
            compare_field("month_wrapped", want.wrapped, beat[OUT_WRAP_BIT]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] op, [15:2] load_year, [19:16] load_month, [24:20] load_day, rest zero
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [13:0] year_now, [17:14] month_now, [22:18] day_now,
    // [27:23] month_length, [28] month_wrapped, rest zero
    logic [31:0] m_axis_tdata;

    date_scoreboard date_board = new();
    bit             quiet = 1'b0;
    int unsigned    rx_hold_cycles = 0;
    int unsigned    cycle_count = 0;
    int unsigned    beats_sent = 0;

    calendar_day_stepper_top #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** calendar_day_stepper_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            date_board.check_result(m_axis_tdata);
    end

    function automatic int unsigned draw_idle();
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Result side: a random stall before each beat, plus the occasional long hold-off.
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
                @(negedge clk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            stall = draw_idle();
            if (stall > 0) begin
                @(negedge clk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [31:0] pack_request(logic [1:0] op, int unsigned y,
                                                 int unsigned m, int unsigned d);
        logic [31:0] beat;
        beat = '0;
        beat[IN_OP_LSB +: 2]    = op;
        beat[IN_YEAR_LSB +: 14] = 14'(y);
        beat[IN_MONTH_LSB +: 4] = 4'(m);
        beat[IN_DAY_LSB +: 5]   = 5'(d);
        return beat;
    endfunction

    // Loads favor month ends and the year limits so that wraps and carries come often.
    function automatic logic [31:0] random_request();
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            return pack_request(OP_UP, $urandom, $urandom, $urandom);
        if (pick < 76)
            return pack_request(OP_DOWN, $urandom, $urandom, $urandom);
        if (pick < 80)
            return pack_request(OP_UNUSED, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 9))
            0: y = 0;
            1: y = YEAR_LIMIT;
            2: y = $urandom_range(0, 16383);
            3: y = $urandom_range(0, 99) * 100;
            default: y = $urandom_range(0, YEAR_LIMIT);
        endcase
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        d = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(25, 31);
        return pack_request(OP_LOAD, y, m, d);
    endfunction

    task automatic send_request(input logic [31:0] beat);
        int unsigned gap;
        gap = draw_idle();
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = beat;
        do @(posedge clk); while (!s_axis_tready);
        date_board.note_input(beat);
        beats_sent++;
    endtask

    task automatic send_load(input int unsigned y, input int unsigned m, input int unsigned d);
        send_request(pack_request(OP_LOAD, y, m, d));
    endtask

    task automatic send_step(input logic [1:0] op);
        send_request(pack_request(op, 0, 0, 0));
    endtask

    // Stops offering beats and waits until every expected result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (date_board.expected_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_wrap_mode(input logic value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(4 * REG_WRAP_IN_MONTH);
        pwdata  = {31'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        date_board.wrap_in_month = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_wrap_mode(1'b0);

        // Calendar mode: month and year carries, leap Februaries, clamping.
        send_step(OP_UP);
        send_step(OP_DOWN);
        send_step(OP_DOWN);
        send_step(OP_UP);
        send_load(2000, 2, 28);
        send_step(OP_UP);
        send_step(OP_UP);
        send_load(1900, 2, 29);
        send_load(2004, 2, 31);
        send_load(0, 2, 15);
        send_load(YEAR_LIMIT, 12, 31);
        send_step(OP_UP);
        send_step(OP_DOWN);
        send_load(16383, 15, 31);
        send_load(0, 0, 0);
        send_step(OP_UNUSED);
        send_load(2023, 4, 31);
        send_load(12345, 13, 0);
        wait_for_results();

        // Wrap-in-month mode: the day wraps and the month stays.
        write_wrap_mode(1'b1);
        send_load(2000, 1, 31);
        send_step(OP_UP);
        send_step(OP_DOWN);
        send_load(2001, 2, 28);
        send_step(OP_UP);
        send_step(OP_DOWN);
        send_load(2000, 12, 31);
        send_step(OP_UP);

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            write_wrap_mode(phase[0]);
            for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
                quiet = (i >= 60 && i < 90) || (phase == 2 && i >= 100 && i < 130);
                if (phase == 0 && i == 120)
                    wait_for_results();
                // Hold the result side off while beats keep coming, so the input stalls.
                if (phase == 2 && i == 100)
                    rx_hold_cycles = 90;
                send_request(random_request());
            end
        end
        quiet = 1'b0;
        wait_for_results();
        repeat (4) @(posedge clk);

        if (date_board.expected_q.size() != 0) begin
            date_board.failures++;
            $error("%0d expected results never arrived", date_board.expected_q.size());
        end
        $display("Sent %0d request beats in both wrap modes; checked %0d results.",
                 beats_sent, date_board.results_checked);
        $display("Results with a month wrap: %0d; year carries across the limit: %0d.",
                 date_board.wraps_flagged, date_board.year_carries);
        if (date_board.failures == 0)
            $display("** calendar_day_stepper_top: PASSED **");
        else
            $display("** calendar_day_stepper_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/cds_pkg.sv
rtl/core/cds_next.sv
rtl/core/calendar_day_stepper_top.sv
rtl/core/cds_checker.sv
sim/calendar_day_stepper_top_tb.sv
